>>> rtl/clew_pkg.sv
// ----------------------------------------------------------------------------
// clew_pkg
// Shared types, codes and tables for the character-LCD expander writer.
// ----------------------------------------------------------------------------
package clew_pkg;

  typedef enum logic [1:0] {
    CMD_COMMAND = 2'd0,
    CMD_DATA    = 2'd1,
    CMD_CHAR    = 2'd2,
    CMD_CURSOR  = 2'd3
  } cmd_t;

  // one classified write waiting for the serializer
  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       rs;
  } entry_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int BEATS       = 6;
  localparam int BEAT_W      = $clog2(BEATS);

  localparam logic [7:0] SET_DDRAM   = 8'h80;
  localparam logic [7:0] LINE_BASE_1 = 8'h00;
  localparam logic [7:0] LINE_BASE_2 = 8'h40;
  localparam logic [7:0] LINE_BASE_3 = 8'h14;
  localparam logic [7:0] LINE_BASE_4 = 8'h54;

  localparam logic [7:0] CHR_YO_UC   = 8'd168;
  localparam logic [7:0] CHR_YO_LC   = 8'd184;
  localparam logic [7:0] LCD_YO_UC   = 8'd162;
  localparam logic [7:0] LCD_YO_LC   = 8'd181;
  localparam logic [7:0] CYR_FIRST   = 8'd192;

  localparam logic [7:0] CYR_MAP [64] = '{
    8'd65,  8'd160, 8'd66,  8'd161, 8'd224, 8'd69,  8'd163, 8'd164,
    8'd165, 8'd166, 8'd75,  8'd167, 8'd77,  8'd72,  8'd79,  8'd168,
    8'd80,  8'd67,  8'd84,  8'd169, 8'd170, 8'd88,  8'd225, 8'd171,
    8'd172, 8'd226, 8'd173, 8'd174, 8'd98,  8'd175, 8'd176, 8'd177,
    8'd97,  8'd178, 8'd179, 8'd180, 8'd227, 8'd101, 8'd182, 8'd183,
    8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd111, 8'd190,
    8'd112, 8'd99,  8'd191, 8'd121, 8'd228, 8'd120, 8'd229, 8'd192,
    8'd193, 8'd230, 8'd194, 8'd195, 8'd196, 8'd197, 8'd198, 8'd199
  };

  function automatic logic [7:0] map_char(input logic [7:0] c);
    logic [7:0] r;
    if (c == CHR_YO_UC)       r = LCD_YO_UC;
    else if (c == CHR_YO_LC)  r = LCD_YO_LC;
    else if (c >= CYR_FIRST)  r = CYR_MAP[c[5:0]];
    else                      r = c;
    return r;
  endfunction

endpackage

>>> rtl/char_lcd_expander_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_expander_writer
// One LCD write in, six port-expander bytes out for a 4-bit character bus.
// ----------------------------------------------------------------------------
// Each accepted write produces six output beats (upper nibble then lower,
// each as E low, E high, E low), one beat per cycle when the sink does not
// stall; the serializer's beat counter steps through them. A two-entry
// queue sits between the classifier and the serializer, so writes are
// accepted while earlier ones are still going out. backlight_on resets to
// 1 and is applied to bytes as they are emitted.
module char_lcd_expander_writer import clew_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] value,
  input  logic [7:0] column,
  input  logic [7:0] row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] expander_byte,
  output logic       last
);

  logic   backlight_on;
  entry_t front_entry;
  entry_t q_data;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  logic   q_push;

  always_ff @(posedge clk) begin
    if (rst)            backlight_on <= 1'b1;
    else if (cfg_write) backlight_on <= cfg_data;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  clew_front u_front (
    .command (command),
    .value   (value),
    .column  (column),
    .row     (row),
    .entry   (front_entry)
  );

  clew_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_entry),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  clew_back u_back (
    .clk           (clk),
    .rst           (rst),
    .backlight     (backlight_on),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .expander_byte (expander_byte),
    .last          (last)
  );

endmodule

>>> rtl/clew_front.sv
// ----------------------------------------------------------------------------
// clew_front
// Classifies one LCD write into the bus byte and register select.
// ----------------------------------------------------------------------------
module clew_front import clew_pkg::*; (
  input  logic [1:0] command,
  input  logic [7:0] value,
  input  logic [7:0] column,
  input  logic [7:0] row,
  output entry_t     entry
);

  logic [7:0] line_base;
  logic [7:0] addr;

  always_comb begin
    unique case (row)
      8'd2:    line_base = LINE_BASE_2;
      8'd3:    line_base = LINE_BASE_3;
      8'd4:    line_base = LINE_BASE_4;
      default: line_base = LINE_BASE_1;
    endcase
    addr = line_base + column - 8'd1;
  end

  always_comb begin
    unique case (cmd_t'(command))
      CMD_COMMAND: begin
        entry.lcd_byte = value;
        entry.rs       = 1'b0;
      end
      CMD_DATA: begin
        entry.lcd_byte = value;
        entry.rs       = 1'b1;
      end
      CMD_CHAR: begin
        entry.lcd_byte = map_char(value);
        entry.rs       = 1'b1;
      end
      default: begin
        entry.lcd_byte = SET_DDRAM | addr;
        entry.rs       = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/clew_queue.sv
// ----------------------------------------------------------------------------
// clew_queue
// Short FIFO between the classifier and the serializer.
// ----------------------------------------------------------------------------
module clew_queue import clew_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   empty
);

  entry_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/clew_back.sv
// ----------------------------------------------------------------------------
// clew_back
// Serializes one bus byte into six expander beats, two nibbles of E strobe.
// ----------------------------------------------------------------------------
module clew_back import clew_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       backlight,
  input  logic       q_empty,
  input  entry_t     q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] expander_byte,
  output logic       last
);

  entry_t             cur;
  logic               busy;
  logic [BEAT_W-1:0]  beat;
  logic               done;
  logic [3:0]         nib;
  logic               strobe;

  assign out_valid = busy;
  assign last      = (beat == BEAT_W'(BEATS - 1));
  assign done      = busy && !out_stall && last;
  assign q_pop     = !q_empty && (!busy || done);

  // beats 0..2 carry the upper nibble, 3..5 the lower; E high in the middle
  assign nib    = (beat < BEAT_W'(BEATS / 2)) ? cur.lcd_byte[7:4] : cur.lcd_byte[3:0];
  assign strobe = (beat == BEAT_W'(1)) || (beat == BEAT_W'(4));
  assign expander_byte = {nib, backlight, strobe, 1'b0, cur.rs};

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      beat <= '0;
    end else if (done) begin
      busy <= 1'b0;
      beat <= '0;
    end else if (busy && !out_stall) begin
      beat <= beat + 1'b1;
    end
  end

endmodule

>>> rtl/clew_checker.sv
// ----------------------------------------------------------------------------
// clew_checker
// Port-level checks on the expander beat stream, bound to the top level.
// ----------------------------------------------------------------------------
module clew_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] expander_byte,
  input logic       last
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(expander_byte) && $stable(last))
    else $error("stalled output beat changed");

  // a sequence runs without gaps until its last beat
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("gap inside a six-beat sequence");

  // the last beat is an E-low beat
  a_last_e_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !expander_byte[2])
    else $error("E high on last beat");

  // E high is followed by E low with the same nibble and RS
  a_strobe: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && expander_byte[2] |=>
      out_valid && !expander_byte[2] &&
      expander_byte[7:4] == $past(expander_byte[7:4]) &&
      expander_byte[0] == $past(expander_byte[0]))
    else $error("E strobe not closed on same nibble");

endmodule

bind char_lcd_expander_writer clew_checker u_clew_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .expander_byte (expander_byte),
  .last          (last)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the character-LCD expander writer. Writes of every kind go
// in under random idling and stalls. A scoreboard predicts the six expander
// beats of each write and checks every beat that leaves the block.
// ----------------------------------------------------------------------------
module tb;
  import clew_pkg::*;

  localparam int         IDLE_PCT     = 18;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         REPORT_MAX   = 10;
  localparam logic [7:0] E_HIGH       = 8'h04;
  localparam logic [7:0] SET_ADDR     = 8'h80;

  typedef struct packed {
    logic [7:0] xbyte;
    logic       last;
  } beat_t;

  class expander_beat_board;
    logic       backlight;
    logic [7:0] glyph [64];
    beat_t      beats_due [$];
    int         mismatches;

    function new();
      backlight  = 1'b1;
      mismatches = 0;
      glyph = '{
        8'd65,  8'd160, 8'd66,  8'd161, 8'd224, 8'd69,  8'd163, 8'd164,
        8'd165, 8'd166, 8'd75,  8'd167, 8'd77,  8'd72,  8'd79,  8'd168,
        8'd80,  8'd67,  8'd84,  8'd169, 8'd170, 8'd88,  8'd225, 8'd171,
        8'd172, 8'd226, 8'd173, 8'd174, 8'd98,  8'd175, 8'd176, 8'd177,
        8'd97,  8'd178, 8'd179, 8'd180, 8'd227, 8'd101, 8'd182, 8'd183,
        8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd111, 8'd190,
        8'd112, 8'd99,  8'd191, 8'd121, 8'd228, 8'd120, 8'd229, 8'd192,
        8'd193, 8'd230, 8'd194, 8'd195, 8'd196, 8'd197, 8'd198, 8'd199
      };
    endfunction

    // byte that goes onto the LCD bus for one write
    function logic [7:0] lcd_byte_for(cmd_t cmd, logic [7:0] val, logic [7:0] col,
                                      logic [7:0] line);
      logic [7:0] base;
      case (cmd)
        CMD_COMMAND, CMD_DATA: return val;
        CMD_CHAR: begin
          if (val == 8'd168) return 8'd162;
          if (val == 8'd184) return 8'd181;
          if (val >= 8'd192) return glyph[val[5:0]];
          return val;
        end
        default: begin
          case (line)
            8'd2:    base = 8'h40;
            8'd3:    base = 8'h14;
            8'd4:    base = 8'h54;
            default: base = 8'h00;
          endcase
          return SET_ADDR | 8'(base + col - 8'd1);
        end
      endcase
    endfunction

    function void note_write(cmd_t cmd, logic [7:0] val, logic [7:0] col, logic [7:0] line);
      logic [7:0] b;
      logic [7:0] nb;
      logic       rs;
      b  = lcd_byte_for(cmd, val, col, line);
      rs = (cmd == CMD_DATA) || (cmd == CMD_CHAR);
      for (int h = 0; h < 2; h++) begin
        nb = {(h == 0) ? b[7:4] : b[3:0], backlight, 1'b0, 1'b0, rs};
        beats_due.push_back('{nb, 1'b0});
        beats_due.push_back('{nb | E_HIGH, 1'b0});
        beats_due.push_back('{nb, h == 1});
      end
    endfunction

    function void check_beat(logic [7:0] xb, logic lst);
      beat_t want;
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected beat: expander_byte=%02h last=%0b", xb, lst);
        return;
      end
      want = beats_due.pop_front();
      if (xb !== want.xbyte || lst !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("beat mismatch: expander_byte exp %02h got %02h, last exp %0b got %0b",
                   want.xbyte, xb, want.last, lst);
      end
    endfunction

    function int pending();
      return beats_due.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] command;
  logic [7:0] value;
  logic [7:0] column;
  logic [7:0] row;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] expander_byte;
  logic       last;

  expander_beat_board board;
  logic               steady;
  int                 quiet_cycles;

  char_lcd_expander_writer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .value         (value),
    .column        (column),
    .row           (row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .expander_byte (expander_byte),
    .last          (last)
  );

  always #1 clk = ~clk;

  task automatic send_write(cmd_t cmd, logic [7:0] val, logic [7:0] col, logic [7:0] line);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= val;
    column   <= col;
    row      <= line;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_write(cmd, val, col, line);
  endtask

  // backlight is applied at emission, so only change it with the block drained
  task automatic set_backlight(logic on);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= on;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.backlight = on;
  endtask

  task automatic random_burst(int count);
    cmd_t       cmd;
    logic [7:0] val;
    logic [7:0] col;
    logic [7:0] line;
    repeat (count) begin
      cmd = cmd_t'($urandom_range(3));
      val = 8'($urandom);
      if (cmd == CMD_CHAR && $urandom_range(1) == 1) val = 8'($urandom_range(255, 160));
      if ($urandom_range(9) == 0) val = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
      line = ($urandom_range(1) == 1) ? 8'($urandom_range(4, 1)) : 8'($urandom);
      col  = ($urandom_range(1) == 1) ? 8'($urandom_range(20, 1)) : 8'($urandom);
      send_write(cmd, val, col, line);
    end
  endtask

  // sink side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_beat(expander_byte, last);
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("char_lcd_expander_writer regression: fail");
        $finish;
      end
    end
  end

  initial begin
    board        = new();
    clk          = 1'b0;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_data     = 1'b0;
    in_valid     = 1'b0;
    command      = CMD_COMMAND;
    value        = 8'h00;
    column       = 8'h00;
    row          = 8'h00;
    out_stall    = 1'b0;
    steady       = 1'b0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_backlight(1'b1);
    send_write(CMD_COMMAND, 8'h00, 8'($urandom), 8'($urandom));
    send_write(CMD_COMMAND, 8'hFF, 8'($urandom), 8'($urandom));
    send_write(CMD_DATA,    8'hA5, 8'($urandom), 8'($urandom));
    send_write(CMD_DATA,    8'h5A, 8'($urandom), 8'($urandom));
    // the two yo letters, table ends, bytes just outside the table
    send_write(CMD_CHAR,    8'd168, 8'($urandom), 8'($urandom));
    send_write(CMD_CHAR,    8'd184, 8'($urandom), 8'($urandom));
    send_write(CMD_CHAR,    8'd192, 8'($urandom), 8'($urandom));
    send_write(CMD_CHAR,    8'd255, 8'($urandom), 8'($urandom));
    send_write(CMD_CHAR,    8'd191, 8'($urandom), 8'($urandom));
    send_write(CMD_CHAR,    8'd167, 8'($urandom), 8'($urandom));
    send_write(CMD_CHAR,    8'h41,  8'($urandom), 8'($urandom));
    send_write(CMD_CHAR,    8'd200, 8'($urandom), 8'($urandom));
    // cursor: each line, row out of range, column zero and wrap
    send_write(CMD_CURSOR,  8'($urandom), 8'd1,   8'd1);
    send_write(CMD_CURSOR,  8'($urandom), 8'd20,  8'd2);
    send_write(CMD_CURSOR,  8'($urandom), 8'd1,   8'd3);
    send_write(CMD_CURSOR,  8'($urandom), 8'd20,  8'd4);
    send_write(CMD_CURSOR,  8'($urandom), 8'd0,   8'd0);
    send_write(CMD_CURSOR,  8'($urandom), 8'd255, 8'd5);
    send_write(CMD_CURSOR,  8'($urandom), 8'd128, 8'd255);
    send_write(CMD_CURSOR,  8'($urandom), 8'd0,   8'd4);

    set_backlight(1'b0);
    random_burst(60);
    set_backlight(1'b1);
    steady = 1'b1;
    random_burst(120);
    steady = 1'b0;
    random_burst(80);
    set_backlight(1'b0);
    random_burst(90);

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("char_lcd_expander_writer regression: pass");
    end else begin
      $display("char_lcd_expander_writer regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/clew_pkg.sv
rtl/clew_front.sv
rtl/clew_queue.sv
rtl/clew_back.sv
rtl/char_lcd_expander_writer.sv
rtl/clew_checker.sv
test/tb.sv
